// File: rtl/ggah_pkg.sv
// package: payload types, aes tables and round helpers for the label hash
package ggah_pkg;

  localparam int TWEAK_STEP = 2;
  localparam int NUM_ROUNDS = 10;

  // configuration register indexes
  localparam logic [1:0] CFG_ROLE      = 2'd0;
  localparam logic [1:0] CFG_HASH_KIND = 2'd1;
  localparam logic [1:0] CFG_OFFSET_LO = 2'd2;
  localparam logic [1:0] CFG_OFFSET_HI = 2'd3;

  // role and hash kind codes
  localparam logic ROLE_GARBLER   = 1'b0;
  localparam logic ROLE_EVALUATOR = 1'b1;
  localparam logic KIND_FIXED     = 1'b0;
  localparam logic KIND_LABEL     = 1'b1;

  typedef struct packed {
    logic [31:0] table_index;
    logic [63:0] right_label_hi;
    logic [63:0] right_label_lo;
    logic [63:0] left_label_hi;
    logic [63:0] left_label_lo;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic [63:0] hash_hi;
    logic [63:0] hash_lo;
  } out_item_t;

  // sideband that travels with each hash along the cell chain
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic       last;
    logic       combine;
    logic       first;
  } tag_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // fixed key 00 11 22 .. ff, byte 0 in bits 7:0
  localparam logic [127:0] FIXED_KEY = 128'hffeeddccbbaa99887766554433221100;

  // round constants, index r-1 for round r
  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // one step of the key schedule; byte i of a word sits at bits 8i+7..8i
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w3;
    logic [31:0] t;
    logic [127:0] n;
    w3 = k[127:96];
    t = {SBOX[w3[7:0]], SBOX[w3[31:24]], SBOX[w3[23:16]], SBOX[w3[15:8]] ^ rc};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    next_key = n;
  endfunction

  // subbytes, shiftrows and optional mixcolumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0] n [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        n[i + 4 * c] = SBOX[s[8 * (i + 4 * ((c + i) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = n[4 * c]; a1 = n[4 * c + 1]; a2 = n[4 * c + 2]; a3 = n[4 * c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (mix) begin
        n[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        n[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        n[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        n[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[8 * i +: 8] = n[i];
    end
    aes_round = o;
  endfunction

  // fixed round keys, computed at elaboration
  function automatic logic [127:0] fixed_round_key(input int r);
    logic [127:0] k;
    k = FIXED_KEY;
    for (int j = 0; j < r; j++) begin
      k = next_key(k, RCON[j]);
    end
    fixed_round_key = k;
  endfunction

endpackage

// File: rtl/ggah_cell.sv
// one aes round cell: state round, key schedule step and sideband
module ggah_cell
  import ggah_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [3:0]     round_idx,
  input  tag_t           tag_in,
  input  logic [127:0]   state_in,
  input  logic [127:0]   key_in,
  input  logic [127:0]   feed_in,
  output tag_t           tag_out,
  output logic [127:0]   state_out,
  output logic [127:0]   key_out,
  output logic [127:0]   feed_out
);

  logic [127:0] rk_fixed;
  logic [127:0] rk_label;
  logic [127:0] rk;
  logic         mix;
  tag_t         tag_r;
  logic [127:0] state_r;
  logic [127:0] key_r;
  logic [127:0] feed_r;

  // pick the round key for this cell
  always_comb begin
    mix      = (round_idx != 4'(NUM_ROUNDS));
    rk_fixed = fixed_round_key(int'(round_idx));
    rk_label = next_key(key_in, RCON[round_idx - 4'd1]);
    rk       = (tag_in.kind == KIND_LABEL) ? rk_label : rk_fixed;
  end

  // hand everything to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= aes_round(state_in, mix) ^ rk;
      key_r   <= rk_label;
      feed_r  <= feed_in;
    end
  end

  assign tag_out   = tag_r;
  assign state_out = state_r;
  assign key_out   = key_r;
  assign feed_out  = feed_r;

endmodule

// File: rtl/ggah_feed.sv
// front end: holds an item and issues one hash block per cycle while en lets the chain advance
module ggah_feed
  import ggah_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_item_t       in_data,
  input  logic           role,
  input  logic           hash_kind,
  input  logic [127:0]   offset,
  input  logic           en,
  output tag_t           tag,
  output logic [127:0]   state,
  output logic [127:0]   key,
  output logic [127:0]   feed
);

  in_item_t     item_r;
  logic         busy_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic         busy_nxt;
  logic [1:0]   top;
  logic         issue;
  logic [127:0] label;
  logic [31:0]  tw;
  logic [127:0] xblk;

  assign top      = (role == ROLE_EVALUATOR) ? 2'd1 : 2'd3;
  assign issue    = busy_r && en;
  assign in_ready = !busy_r || (issue && cnt_r == top);

  // sequence counter over the hashes of one item
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (issue) begin
      if (cnt_r == top) begin
        busy_nxt = 1'b0;
        cnt_nxt  = 2'd0;
      end else begin
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // choose label and tweak for this hash
  always_comb begin
    logic right;
    logic flip;
    if (role == ROLE_EVALUATOR) begin
      right = cnt_r[0];
      flip  = 1'b0;
    end else begin
      right = cnt_r[1];
      flip  = cnt_r[0];
    end
    label = right ? {item_r.right_label_hi, item_r.right_label_lo}
                  : {item_r.left_label_hi, item_r.left_label_lo};
    if (flip) begin
      label = label ^ offset;
    end
    tw = 32'(item_r.table_index * 32'(TWEAK_STEP)) + {31'd0, right};
    xblk = {label[126:0], 1'b0} ^ {96'd0, tw};
    tag.valid   = issue;
    tag.kind    = hash_kind;
    tag.last    = (cnt_r == top);
    tag.combine = (role == ROLE_EVALUATOR);
    tag.first   = (role == ROLE_EVALUATOR) && !cnt_r[0];
    if (hash_kind == KIND_LABEL) begin
      state = {96'd0, tw} ^ label;
      key   = label;
      feed  = '0;
    end else begin
      state = xblk ^ FIXED_KEY;
      key   = FIXED_KEY;
      feed  = xblk;
    end
  end

endmodule

// File: rtl/garbled_gate_aes_hash.sv
// top level: half-gates label hash as a chain of ten aes round cells
//
//  channel  | handshake              | payload
//  in_      | in_valid / in_ready    | in_data  (in_item_t)
//  out_     | out_valid / out_ready  | out_data (out_item_t)
//  cfg_     | cfg_we                 | cfg_index, cfg_data
//
// one hash leaves the front end per cycle while the chain advances: four
// hashes per item as garbler, two as evaluator; each result passes the round
// cell registers and the output register; the evaluator's first hash is held in acc_r.
// the whole chain advances only when the output register is free or taken,
// so a stall on out_ready freezes every cell in place.
// reset clears configuration and control; fixed round keys are constants.
module garbled_gate_aes_hash
  import ggah_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic         role_r;
  logic         kind_r;
  logic [63:0]  off_lo_r;
  logic [63:0]  off_hi_r;
  logic         en;
  tag_t         tag   [NUM_ROUNDS + 1];
  logic [127:0] st    [NUM_ROUNDS + 1];
  logic [127:0] ky    [NUM_ROUNDS + 1];
  logic [127:0] fd    [NUM_ROUNDS + 1];
  logic [127:0] acc_r;
  logic [127:0] hash;
  out_item_t    out_r;
  logic         out_v_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r   <= ROLE_GARBLER;
      kind_r   <= KIND_FIXED;
      off_lo_r <= '0;
      off_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROLE:      role_r   <= cfg_data[0];
        CFG_HASH_KIND: kind_r   <= cfg_data[0];
        CFG_OFFSET_LO: off_lo_r <= cfg_data;
        CFG_OFFSET_HI: off_hi_r <= cfg_data;
        default:       role_r   <= role_r;
      endcase
    end
  end

  assign en = !out_v_r || out_ready;

  ggah_feed u_feed (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .role(role_r), .hash_kind(kind_r), .offset({off_hi_r, off_lo_r}), .en,
    .tag(tag[0]), .state(st[0]), .key(ky[0]), .feed(fd[0])
  );

  // chain of round cells
  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_cell
    ggah_cell u_cell (
      .clk, .rst_n, .en, .round_idx(4'(g)),
      .tag_in(tag[g - 1]), .state_in(st[g - 1]), .key_in(ky[g - 1]),
      .feed_in(fd[g - 1]),
      .tag_out(tag[g]), .state_out(st[g]), .key_out(ky[g]), .feed_out(fd[g])
    );
  end

  assign hash = st[NUM_ROUNDS] ^ fd[NUM_ROUNDS];

  // evaluator partial xor and output register
  always_ff @(posedge clk) begin
    if (en && tag[NUM_ROUNDS].valid && tag[NUM_ROUNDS].first) begin
      acc_r <= hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= tag[NUM_ROUNDS].valid && !tag[NUM_ROUNDS].first;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.hash_lo <= tag[NUM_ROUNDS].combine ? 64'(hash ^ acc_r) : hash[63:0];
      out_r.hash_hi <= tag[NUM_ROUNDS].combine ? (hash[127:64] ^ acc_r[127:64])
                                               : hash[127:64];
      out_r.last    <= tag[NUM_ROUNDS].last;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: rtl/ggah_checker.sv
// port checker for the label hash, bound to the top level
module ggah_port_checker
  import ggah_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // no result comes out straight after reset release
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result without an item");

  // ready after reset release
  a_ready_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

endmodule

bind garbled_gate_aes_hash ggah_port_checker u_ggah_port_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data
);
